[design/spif_pkg.sv]
// ----------------------------------------------------------------------------
// spif_pkg
// Shared widths, command and field codes and default sizes for the sample
// playback engine.
// ----------------------------------------------------------------------------
package spif_pkg;

    localparam int MEM_DEPTH_DEF   = 65536;
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int FADE_LENGTH_DEF = 256;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 4;
    localparam int FSEL_W   = 3;
    localparam int FVAL_W   = 17;
    localparam int PHASE_W  = 31;
    localparam int FRAC_W   = 12;
    localparam int IDX_W    = PHASE_W - FRAC_W;
    localparam int SHIFT_W  = 4;
    localparam int LEN_W    = 16;
    localparam int END_W    = 17;
    localparam int SUM_W    = IDX_W + 1;
    localparam int CMP_W    = SUM_W + 1;
    localparam int FADE_W   = FRAC_W + 1;

    // remainder unit: bits retired per cycle and cycle count
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = (IDX_W + MOD_BITS - 1) / MOD_BITS;
    localparam int MOD_NUM_W = MOD_BITS * MOD_STEPS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_FIELD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP       = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;

    localparam logic [FSEL_W-1:0] FLD_SHIFT = 3'd0;
    localparam logic [FSEL_W-1:0] FLD_LEN   = 3'd1;
    localparam logic [FSEL_W-1:0] FLD_START = 3'd2;
    localparam logic [FSEL_W-1:0] FLD_OFF   = 3'd3;
    localparam logic [FSEL_W-1:0] FLD_END   = 3'd4;
    // field codes with no descriptor behind them
    localparam logic [FSEL_W-1:0] FLD_FIRST_UNUSED = 3'd5;
    localparam logic [FSEL_W-1:0] FLD_LAST_UNUSED  = 3'd7;

endpackage

[design/spif_in_if.sv]
// ----------------------------------------------------------------------------
// spif_in_if
// Command channel of the sample playback engine: valid, ready and payload.
// ----------------------------------------------------------------------------
interface spif_in_if import spif_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [ADDR_W-1:0]         mem_address;
    logic signed [SAMPLE_W-1:0] mem_data;
    logic [SLOT_W-1:0]         slot;
    logic [FSEL_W-1:0]         field_select;
    logic [FVAL_W-1:0]         field_value;
    logic [PHASE_W-1:0]        phase;

    modport source (output valid, command, mem_address, mem_data, slot, field_select,
                    field_value, phase, input ready);
    modport sink   (input valid, command, mem_address, mem_data, slot, field_select,
                    field_value, phase, output ready);
endinterface

[design/spif_out_if.sv]
// ----------------------------------------------------------------------------
// spif_out_if
// Result channel of the sample playback engine: valid, ready and payload.
// ----------------------------------------------------------------------------
interface spif_out_if import spif_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_of_range;

    modport source (output valid, sample_out, out_of_range, input ready);
    modport sink   (input valid, sample_out, out_of_range, output ready);
endinterface

[design/sample_playback_interp_fade_top.sv]
// ----------------------------------------------------------------------------
// sample_playback_interp_fade_top
// Wavetable sample playback with linear interpolation and a fade at the end.
// ----------------------------------------------------------------------------
// i_in carries items: sample word writes, descriptor field writes and lookups.
// o_out carries one result per lookup; writes give none.
// Two stages. The index stage latches the slot descriptor at acceptance and,
// for a lookup with a nonzero loop length, runs a remainder unit that retires
// 4 bits a cycle. The playback stage reads two samples from the sample memory
// on consecutive cycles, multiplies, applies the fade multiply and hands the
// result to an output register.
// A lookup occupies the playback stage from its reads through the push to the
// output register; an out-of-range lookup skips the reads and goes straight to
// the push. The stage takes no new lookup until it is idle again; writes pass
// at one item per cycle while the playback stage is idle.
// The output register decouples the two sides: a new item is accepted while a
// result waits. A stalled receiver holds the result and, once the playback
// stage has its next result ready, stalls the stages behind it.
// Reset clears descriptors and control state; the sample memory is not
// cleared. MEM_DEPTH must be a power of two, addresses wrap at its size.
// ----------------------------------------------------------------------------
module sample_playback_interp_fade_top import spif_pkg::*; #(
    parameter int MEM_DEPTH   = MEM_DEPTH_DEF,
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int FADE_LENGTH = FADE_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spif_in_if.sink     i_in,
    spif_out_if.source  o_out
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DW    = $clog2(FADE_LENGTH + 1);
    localparam int RECIP = (1 << 24) / FADE_LENGTH;

    typedef enum logic [2:0] {
        B_IDLE, B_RD0, B_RD1, B_MUL, B_SCALE, B_PUSH
    } t_b_state;

    function automatic logic [SW-1:0] f_wrap(input logic [SLOT_W-1:0] v);
        logic [SLOT_W:0] r;
        r = {1'b0, v};
        for (int k = 0; k < (1 << SLOT_W); k++) begin
            if (int'(r) >= NUM_SLOTS) r = r - (SLOT_W + 1)'(NUM_SLOTS);
        end
        return SW'(r);
    endfunction

    // descriptors
    logic [SHIFT_W-1:0] r_d_shift [NUM_SLOTS];
    logic [LEN_W-1:0]   r_d_len   [NUM_SLOTS];
    logic [LEN_W-1:0]   r_d_start [NUM_SLOTS];
    logic [LEN_W-1:0]   r_d_off   [NUM_SLOTS];
    logic [END_W-1:0]   r_d_end   [NUM_SLOTS];

    // index stage
    logic                       r_a_valid;
    logic [CMD_W-1:0]           r_a_cmd;
    logic [ADDR_W-1:0]          r_a_addr;
    logic [SAMPLE_W-1:0]        r_a_data;
    logic [FRAC_W-1:0]          r_a_frac;
    logic [LEN_W-1:0]           r_a_len;
    logic [LEN_W-1:0]           r_a_start;
    logic [LEN_W-1:0]           r_a_off;
    logic [END_W-1:0]           r_a_end;
    logic [MOD_NUM_W-1:0]       r_a_num;
    logic [LEN_W-1:0]           r_a_rem;
    logic [MOD_CNT_W-1:0]       r_a_cnt;

    // playback stage
    t_b_state                   r_b_state;
    logic [AW-1:0]              r_b_idx_p1;
    logic [FRAC_W-1:0]          r_b_frac;
    logic                       r_b_oor;
    logic                       r_b_fade_on;
    logic [DW-1:0]              r_b_dist;
    logic [FADE_W-1:0]          r_b_q0;
    logic [FADE_W-1:0]          r_b_fade;
    logic signed [SAMPLE_W-1:0] r_s0;
    logic signed [29:0]         r_prod;
    logic signed [SAMPLE_W-1:0] r_interp;
    logic signed [29:0]         r_prod2;

    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_sample;
    logic                       r_o_oor;

    logic                       in_take;
    logic                       a_done;
    logic                       a_hand;
    logic [SW-1:0]              in_slot;
    logic [IDX_W-1:0]           in_shifted;
    logic [MOD_NUM_W-1:0]       n_num;
    logic [LEN_W-1:0]           n_rem;
    logic [IDX_W-1:0]           a_base;
    logic [SUM_W-1:0]           a_idx;
    logic                       a_oor;
    logic                       a_fade_on;
    logic [DW-1:0]              a_dist;
    logic                       mem_we;
    logic [AW-1:0]              rd_addr;
    logic signed [16:0]         b_diff;
    logic [25:0]                b_qprod;
    logic                       b_qinc;
    logic                       o_free;

    assign o_free     = !r_o_valid || o_out.ready;
    assign a_done     = (r_a_cnt == '0);
    assign a_hand     = r_a_valid && a_done && (r_b_state == B_IDLE);
    assign i_in.ready = !r_a_valid || a_hand;
    assign in_take    = i_in.valid && i_in.ready;
    assign in_slot    = f_wrap(i_in.slot);
    assign in_shifted = i_in.phase[PHASE_W-1:FRAC_W] >> r_d_shift[in_slot];

    // long division remainder, MOD_BITS quotient bits per cycle
    always_comb begin
        logic [LEN_W:0] t;
        n_num = r_a_num;
        n_rem = r_a_rem;
        for (int k = 0; k < MOD_BITS; k++) begin
            t = {n_rem, n_num[MOD_NUM_W-1]};
            if (t >= {1'b0, r_a_len}) t = t - {1'b0, r_a_len};
            n_rem = t[LEN_W-1:0];
            n_num = n_num << 1;
        end
    end

    assign a_base    = (r_a_len == '0) ? r_a_num[IDX_W-1:0] : IDX_W'(r_a_rem);
    assign a_idx     = SUM_W'(a_base) + SUM_W'(r_a_start) + SUM_W'(r_a_off);
    assign a_oor     = (CMP_W'(a_idx) + CMP_W'(1)) >= CMP_W'(r_a_end);
    assign a_fade_on = (CMP_W'(a_idx) + CMP_W'(FADE_LENGTH)) >= CMP_W'(r_a_end);
    assign a_dist    = DW'(CMP_W'(r_a_end) - CMP_W'(a_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_d_shift[k] <= '0;
                r_d_len[k]   <= '0;
                r_d_start[k] <= '0;
                r_d_off[k]   <= '0;
                r_d_end[k]   <= '0;
            end
        end else if (in_take && i_in.command == CMD_WRITE_FIELD) begin
            case (i_in.field_select)
                FLD_SHIFT: r_d_shift[in_slot] <= i_in.field_value[SHIFT_W-1:0];
                FLD_LEN:   r_d_len[in_slot]   <= i_in.field_value[LEN_W-1:0];
                FLD_START: r_d_start[in_slot] <= i_in.field_value[LEN_W-1:0];
                FLD_OFF:   r_d_off[in_slot]   <= i_in.field_value[LEN_W-1:0];
                FLD_END:   r_d_end[in_slot]   <= i_in.field_value[END_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_cnt   <= '0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
            r_a_cmd   <= i_in.command;
            r_a_addr  <= i_in.mem_address;
            r_a_data  <= i_in.mem_data;
            r_a_frac  <= i_in.phase[FRAC_W-1:0];
            r_a_len   <= r_d_len[in_slot];
            r_a_start <= r_d_start[in_slot];
            r_a_off   <= r_d_off[in_slot];
            r_a_end   <= r_d_end[in_slot];
            r_a_num   <= MOD_NUM_W'(in_shifted);
            r_a_rem   <= '0;
            if (i_in.command == CMD_LOOKUP && r_d_len[in_slot] != '0) begin
                r_a_cnt <= MOD_CNT_W'(MOD_STEPS);
            end else begin
                r_a_cnt <= '0;
            end
        end else if (a_hand) begin
            r_a_valid <= 1'b0;
        end else if (!a_done) begin
            r_a_num <= n_num;
            r_a_rem <= n_rem;
            r_a_cnt <= r_a_cnt - MOD_CNT_W'(1);
        end
    end

    // sample memory: a write only while the playback stage is idle
    assign mem_we  = a_hand && (r_a_cmd == CMD_WRITE_SAMPLE);
    assign rd_addr = (r_b_state == B_IDLE) ? AW'(a_idx) : r_b_idx_p1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[AW'(r_a_addr)] <= r_a_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign b_diff  = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_s0[SAMPLE_W-1], r_s0};
    assign b_qprod = 26'(r_b_dist) * 26'(RECIP);
    // reciprocal estimate is exact or one low
    assign b_qinc  = (27'(r_b_q0) + 27'(1)) * 27'(FADE_LENGTH) <= 27'({r_b_dist, 12'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_state <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_b_state == B_PUSH && o_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_b_state)
                B_IDLE: begin
                    if (a_hand && r_a_cmd == CMD_LOOKUP) begin
                        r_b_idx_p1  <= AW'(a_idx + SUM_W'(1));
                        r_b_frac    <= r_a_frac;
                        r_b_oor     <= a_oor;
                        r_b_fade_on <= a_fade_on;
                        r_b_dist    <= a_dist;
                        r_b_state   <= a_oor ? B_PUSH : B_RD0;
                    end
                end
                B_RD0: begin
                    r_s0      <= r_rd_data;
                    r_b_q0    <= FADE_W'(b_qprod[25:12]);
                    r_b_state <= B_RD1;
                end
                B_RD1: begin
                    r_prod    <= 30'(b_diff) * 30'($signed({1'b0, r_b_frac}));
                    r_b_fade  <= b_qinc ? r_b_q0 + FADE_W'(1) : r_b_q0;
                    r_b_state <= B_MUL;
                end
                B_MUL: begin
                    r_interp  <= SAMPLE_W'((r_prod >>> FRAC_W) + 30'(r_s0));
                    r_b_state <= B_SCALE;
                end
                B_SCALE: begin
                    r_prod2   <= 30'(r_interp) * 30'($signed({1'b0, r_b_fade}));
                    r_b_state <= B_PUSH;
                end
                B_PUSH: begin
                    if (o_free) begin
                        r_o_oor   <= r_b_oor;
                        if (r_b_oor) begin
                            r_o_sample <= '0;
                        end else if (r_b_fade_on) begin
                            r_o_sample <= SAMPLE_W'(r_prod2 >>> FRAC_W);
                        end else begin
                            r_o_sample <= r_interp;
                        end
                        r_b_state <= B_IDLE;
                    end
                end
                default: r_b_state <= B_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.sample_out   = r_o_sample;
    assign o_out.out_of_range = r_o_oor;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_of_range |-> o_out.sample_out == '0)
        else $error("out of range result with nonzero sample");

    a_mod_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_cnt != '0 |-> r_a_valid && r_a_cmd == CMD_LOOKUP)
        else $error("remainder unit busy without a lookup");

    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_b_state == B_IDLE)
        else $error("sample write while playback stage reads");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !o_out.ready |=> r_o_valid)
        else $error("result dropped under stall");

endmodule
